/* rtl/kmerge_pkg.sv */
`default_nettype none

package kmerge_pkg;

  // Build-time defaults for the top-level parameters.
  localparam int MaxStreamsDef = 16;
  localparam int ValueWidthDef = 32;

  // Fixed field widths of the stream words.
  localparam int CountW    = 5;
  localparam int IndexW    = 4;
  localparam int WordW     = 32;
  localparam int InDataW   = 40;
  localparam int OutDataW  = 40;

  // Stream count in effect after reset.
  localparam logic [CountW-1:0] StreamCountRst = 5'd16;

  // Result kinds carried on the output tuser.
  localparam logic KindValue    = 1'b0;
  localparam logic KindFinished = 1'b1;

  // Request types carried on the input tuser.
  localparam logic ReqDeliver = 1'b0;
  localparam logic ReqEnd     = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } kmerge_state_e;

  // Flags that travel down the cell chain with the scan token.
  typedef struct packed {
    logic tok;
    logic any_wait;
    logic found;
  } scan_t;

  // Per-cell update commands from the sequencer.
  typedef struct packed {
    logic init;
    logic init_use;
    logic load;
    logic load_end;
    logic take;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/kmerge_cell.sv */
`default_nettype none

module kmerge_cell import kmerge_pkg::*; #(
  parameter int VALUE_WIDTH = ValueWidthDef,
  parameter int MAX_STREAMS = MaxStreamsDef,
  parameter int CELL_IDX    = 0
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cell_ctrl_t                     ctrl_i,
  input  wire logic [VALUE_WIDTH-1:0]         wr_value_i,
  input  wire scan_t                          scan_i,
  input  wire logic [$clog2(MAX_STREAMS)-1:0] cand_idx_i,
  input  wire logic [VALUE_WIDTH-1:0]         cand_value_i,
  output scan_t                               scan_o,
  output logic [$clog2(MAX_STREAMS)-1:0]      cand_idx_o,
  output logic [VALUE_WIDTH-1:0]              cand_value_o
);

  localparam int IdxW = $clog2(MAX_STREAMS);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_IDX);
  localparam logic WaitRst = (CELL_IDX < int'(StreamCountRst));

  logic [VALUE_WIDTH-1:0] head_q, head_d;
  logic                   valid_q, valid_d;
  logic                   wait_q, wait_d;
  scan_t                  scan_q, scan_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic                   own_wins;

  // Head update: reinit, refill or end report, and consumption by the merge.
  always_comb begin
    head_d  = head_q;
    valid_d = valid_q;
    wait_d  = wait_q;
    if (ctrl_i.init) begin
      valid_d = 1'b0;
      wait_d  = ctrl_i.init_use;
    end else if (ctrl_i.load && wait_q) begin
      wait_d = 1'b0;
      if (ctrl_i.load_end) begin
        valid_d = 1'b0;
      end else begin
        valid_d = 1'b1;
        head_d  = wr_value_i;
      end
    end else if (ctrl_i.take) begin
      valid_d = 1'b0;
      wait_d  = 1'b1;
    end
  end

  // Compare stage: the incoming candidate is replaced only by a strictly smaller head,
  // so the lowest stream index wins a tie.
  always_comb begin
    own_wins = valid_q && (!scan_i.found || ($signed(head_q) < $signed(cand_value_i)));
    scan_d.tok      = scan_i.tok;
    scan_d.any_wait = scan_i.any_wait | wait_q;
    scan_d.found    = scan_i.found | valid_q;
    idx_d = own_wins ? MyIdx : cand_idx_i;
    val_d = own_wins ? head_q : cand_value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      wait_q  <= WaitRst;
      scan_q  <= '0;
    end else begin
      valid_q <= valid_d;
      wait_q  <= wait_d;
      scan_q  <= scan_d;
    end
  end

  // Head and candidate payload carry no reset.
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    idx_q  <= idx_d;
    val_q  <= val_d;
  end

  assign scan_o       = scan_q;
  assign cand_idx_o   = idx_q;
  assign cand_value_o = val_q;

endmodule

`default_nettype wire

/* rtl/kway_merge_min_selector.sv */
// The scan token steps through the chain of MAX_STREAMS head cells, one cell per
// cycle; the block takes no new input word until it has finished the scan and the
// decision step for the last one.
// A pending output word holds the decision step until it is taken.
// Reset (asynchronous, active low): all heads invalid, streams 0 to 15 awaiting a
// refill, no finished word sent; a stream_count write reinitializes the same way.
`default_nettype none

module kway_merge_min_selector import kmerge_pkg::*; #(
  parameter int MAX_STREAMS = MaxStreamsDef,
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration: stream_count.
  input  wire logic                cfg_we_i,
  input  wire logic [CountW-1:0]   cfg_wdata_i,
  // Input stream.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [3:0] stream_index, [35:4] value, [39:36] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // [0] req_type
  input  wire logic                s_axis_tuser,
  // Output stream.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [31:0] merged_value, [35:32] source_stream, [39:36] zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  // [0] kind
  output logic                     m_axis_tuser
);

  localparam int IdxW = $clog2(MAX_STREAMS);

  kmerge_state_e          state_q, state_d;
  logic                   start_q, start_d;
  logic                   fin_q, fin_d;
  scan_t                  res_scan_q, res_scan_d;
  logic [IdxW-1:0]        res_idx_q, res_idx_d;
  logic [VALUE_WIDTH-1:0] res_val_q, res_val_d;
  logic                   m_valid_q, m_valid_d;
  logic [OutDataW-1:0]    m_data_q, m_data_d;
  logic                   m_user_q, m_user_d;
  logic                   accept;
  logic                   take_en;
  logic [IndexW-1:0]      in_index;
  logic [VALUE_WIDTH+WordW-1:0] in_value_ext;
  logic [VALUE_WIDTH-1:0]       in_value;
  logic [VALUE_WIDTH+WordW-1:0] res_val_ext;
  logic [IdxW+IndexW-1:0]       res_idx_ext;

  scan_t                  chain_scan  [MAX_STREAMS+1];
  logic [IdxW-1:0]        chain_idx   [MAX_STREAMS+1];
  logic [VALUE_WIDTH-1:0] chain_val   [MAX_STREAMS+1];
  logic [MAX_STREAMS-1:0] tok_vec;

  // Input word unpacking; the value is taken as its low VALUE_WIDTH bits.
  assign accept       = s_axis_tvalid && s_axis_tready;
  assign in_index     = s_axis_tdata[IndexW-1:0];
  assign in_value_ext = {{VALUE_WIDTH{1'b0}}, s_axis_tdata[IndexW+WordW-1:IndexW]};
  assign in_value     = in_value_ext[VALUE_WIDTH-1:0];

  // Result fields: sign-extended value and stream index cut to the port widths.
  assign res_val_ext = {{WordW{res_val_q[VALUE_WIDTH-1]}}, res_val_q};
  assign res_idx_ext = {{IndexW{1'b0}}, res_idx_q};

  // The scan token enters the chain with an empty candidate.
  assign chain_scan[0] = '{tok: start_q, any_wait: 1'b0, found: 1'b0};
  assign chain_idx[0]  = '0;
  assign chain_val[0]  = '0;

  // Row of head cells.
  for (genvar gi = 0; gi < MAX_STREAMS; gi++) begin : g_cell
    cell_ctrl_t ctrl;

    assign ctrl.init     = cfg_we_i;
    assign ctrl.init_use = ({{(32-CountW){1'b0}}, cfg_wdata_i} > 32'(gi));
    assign ctrl.load     = accept && ({{(32-IndexW){1'b0}}, in_index} == 32'(gi));
    assign ctrl.load_end = (s_axis_tuser == ReqEnd);
    assign ctrl.take     = take_en && (res_idx_q == IdxW'(gi));

    kmerge_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_STREAMS (MAX_STREAMS),
      .CELL_IDX    (gi)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .wr_value_i   (in_value),
      .scan_i       (chain_scan[gi]),
      .cand_idx_i   (chain_idx[gi]),
      .cand_value_i (chain_val[gi]),
      .scan_o       (chain_scan[gi+1]),
      .cand_idx_o   (chain_idx[gi+1]),
      .cand_value_o (chain_val[gi+1])
    );

    assign tok_vec[gi] = chain_scan[gi+1].tok;
  end

  // Sequencer: accept a word, run the scan, then emit or stay silent.
  always_comb begin
    state_d    = state_q;
    start_d    = 1'b0;
    fin_d      = fin_q;
    res_scan_d = res_scan_q;
    res_idx_d  = res_idx_q;
    res_val_d  = res_val_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    take_en    = 1'b0;
    s_axis_tready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          start_d = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain_scan[MAX_STREAMS].tok) begin
          res_scan_d = chain_scan[MAX_STREAMS];
          res_idx_d  = chain_idx[MAX_STREAMS];
          res_val_d  = chain_val[MAX_STREAMS];
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Decide only when the output register is free.
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
          if (!res_scan_q.any_wait) begin
            if (res_scan_q.found) begin
              take_en   = 1'b1;
              m_valid_d = 1'b1;
              m_user_d  = KindValue;
              m_data_d  = {{(OutDataW-WordW-IndexW){1'b0}},
                           res_idx_ext[IndexW-1:0], res_val_ext[WordW-1:0]};
            end else if (!fin_q) begin
              fin_d     = 1'b1;
              m_valid_d = 1'b1;
              m_user_d  = KindFinished;
              m_data_d  = '0;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A stream_count write restarts the merge.
    if (cfg_we_i) begin
      fin_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      start_q    <= 1'b0;
      fin_q      <= 1'b0;
      res_scan_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      start_q    <= start_d;
      fin_q      <= fin_d;
      res_scan_q <= res_scan_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Result payload carries no reset.
  always_ff @(posedge clk_i) begin
    res_idx_q <= res_idx_d;
    res_val_q <= res_val_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // At most one scan token is in the chain.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one scan token in the cell chain");

  // An accepted word always starts a scan.
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN) && start_q)
    else $error("accepted word did not start a scan");

  // A new output word only comes from the decision step.
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready)) |->
      ($past(state_q) == ST_EMIT))
    else $error("output word appeared outside the decision step");

  // The finished word carries zero data.
  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KindFinished)) |-> (m_axis_tdata == '0))
    else $error("finished word carries nonzero data");

endmodule

`default_nettype wire

/* bench/tb_kway_merge_min_selector.sv */
module tb_kway_merge_min_selector;
  import kmerge_pkg::*;

  localparam int NumWords = 750;
  localparam int IdleWait = MaxStreamsDef + 8;

  // One result word as it appears on the output stream.
  typedef struct packed {
    logic              kind;
    logic [31:0]       value;
    logic [IndexW-1:0] src;
  } merge_word_t;

  // Directed rows either write the stream count or send one input word.
  typedef enum logic {
    ROW_CFG,
    ROW_WORD
  } row_op_e;

  typedef struct packed {
    row_op_e           op;
    logic              req;
    logic [IndexW-1:0] idx;
    logic [31:0]       val;
    logic              typed;
    merge_word_t       res;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CountW-1:0]   cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  kway_merge_min_selector uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Predicted merge state: one head per stream plus the finished flag.
  logic [CountW-1:0]  count_reg;
  logic signed [31:0] head_val [MaxStreamsDef];
  logic               head_ok [MaxStreamsDef];
  logic               refill_wait [MaxStreamsDef];
  logic               fin_sent;

  merge_word_t merged_expected [$];
  row_t        directed_rows [$];
  int          mismatches = 0;
  int          burst_left = 0;

  function automatic int active_streams();
    return (count_reg > MaxStreamsDef) ? MaxStreamsDef : int'(count_reg);
  endfunction

  // A count write restarts every stream, as reset does.
  task automatic merge_config(input logic [CountW-1:0] cnt);
    count_reg = cnt;
    for (int i = 0; i < MaxStreamsDef; i++) begin
      head_val[i]    = '0;
      head_ok[i]     = 1'b0;
      refill_wait[i] = (i < active_streams());
    end
    fin_sent = 1'b0;
  endtask

  // Take one input word, then pick the smallest head once no stream waits.
  task automatic merge_step(input logic req, input logic [IndexW-1:0] idx,
                            input logic [31:0] val, output logic got,
                            output merge_word_t res);
    int   n;
    int   best;
    logic waiting;
    logic found;
    n       = active_streams();
    best    = 0;
    waiting = 1'b0;
    found   = 1'b0;
    got     = 1'b0;
    res     = '0;
    if (int'(idx) < n && refill_wait[idx]) begin
      refill_wait[idx] = 1'b0;
      head_ok[idx]     = (req == ReqDeliver);
      if (req == ReqDeliver) head_val[idx] = val;
    end
    for (int i = 0; i < n; i++) begin
      if (refill_wait[i]) waiting = 1'b1;
      if (head_ok[i] && (!found || head_val[i] < head_val[best])) begin
        best  = i;
        found = 1'b1;
      end
    end
    if (!waiting) begin
      if (found) begin
        head_ok[best]     = 1'b0;
        refill_wait[best] = 1'b1;
        got = 1'b1;
        res.kind  = KindValue;
        res.value = head_val[best];
        res.src   = best[IndexW-1:0];
      end else if (!fin_sent) begin
        fin_sent = 1'b1;
        got = 1'b1;
        res.kind = KindFinished;
      end
    end
  endtask

  task automatic add_row(input row_op_e op, input logic req, input logic [IndexW-1:0] idx,
                         input logic [31:0] val, input logic typed, input logic kind,
                         input logic [31:0] rval, input logic [IndexW-1:0] rsrc);
    row_t r;
    r.op        = op;
    r.req       = req;
    r.idx       = idx;
    r.val       = val;
    r.typed     = typed;
    r.res.kind  = kind;
    r.res.value = rval;
    r.res.src   = rsrc;
    directed_rows.push_back(r);
  endtask

  // Send one word in bursts with random gaps; predict it once accepted.
  task automatic send_word(input logic req, input logic [IndexW-1:0] idx,
                           input logic [31:0] val, input logic typed,
                           input merge_word_t typed_res);
    int          gap;
    logic        got;
    merge_word_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, val, idx};
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    merge_step(req, idx, val, got, res);
    if (typed) merged_expected.push_back(typed_res);
    else if (got) merged_expected.push_back(res);
  endtask

  // Let the block drain: every result in, then the scan latency on top.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (merged_expected.size() != 0) @(posedge clk_i);
    repeat (IdleWait) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CountW-1:0] cnt);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cnt;
    @(posedge clk_i);
    merge_config(cnt);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_noise();
    send_word(logic'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom,
              1'b0, '0);
  endtask

  // Stimulus: directed rows first, then phases of sorted streams with noise mixed in.
  initial begin
    int          words;
    int          phase_words;
    int          pick;
    int          n;
    int          cand [$];
    logic        tie_mode;
    logic        is_end;
    logic        first [MaxStreamsDef];
    longint      last [MaxStreamsDef];
    longint      nxt;
    logic [CountW-1:0] cnt;
    row_t        r;

    merge_config(StreamCountRst);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero streams: any word brings the finished result, then silence.
    add_row(ROW_CFG,  0,         0,  0,            0, 0,            0,            0);
    add_row(ROW_WORD, ReqDeliver, 0,  32'd5,        1, KindFinished, 0,            0);
    add_row(ROW_WORD, ReqEnd,     3,  0,            0, 0,            0,            0);
    // Two streams: extremes, an unsolicited word and an index out of use.
    add_row(ROW_CFG,  0,         0,  32'd2,        0, 0,            0,            0);
    add_row(ROW_WORD, ReqDeliver, 1,  32'h7FFFFFFF, 0, 0,            0,            0);
    add_row(ROW_WORD, ReqDeliver, 1,  0,            0, 0,            0,            0);
    add_row(ROW_WORD, ReqDeliver, 5,  32'd7,        0, 0,            0,            0);
    add_row(ROW_WORD, ReqDeliver, 0,  32'h80000000, 1, KindValue,    32'h80000000, 0);
    add_row(ROW_WORD, ReqEnd,     0,  32'hFFFF0000, 1, KindValue,    32'h7FFFFFFF, 1);
    add_row(ROW_WORD, ReqDeliver, 1,  32'hFFFFFFFF, 1, KindValue,    32'hFFFFFFFF, 1);
    add_row(ROW_WORD, ReqEnd,     1,  0,            1, KindFinished, 0,            0);
    // Three streams: equal heads go out lowest index first.
    add_row(ROW_CFG,  0,         0,  32'd3,        0, 0,            0,            0);
    add_row(ROW_WORD, ReqDeliver, 2,  32'd4,        0, 0,            0,            0);
    add_row(ROW_WORD, ReqDeliver, 0,  32'd4,        0, 0,            0,            0);
    add_row(ROW_WORD, ReqDeliver, 1,  32'd9,        1, KindValue,    32'd4,        0);
    add_row(ROW_WORD, ReqEnd,     0,  0,            1, KindValue,    32'd4,        2);
    add_row(ROW_WORD, ReqEnd,     15, 0,            0, 0,            0,            0);
    add_row(ROW_WORD, ReqDeliver, 2,  32'hFFFFFFFB, 1, KindValue,    32'hFFFFFFFB, 2);
    // A count above the capacity acts as the capacity.
    add_row(ROW_CFG,  0,         0,  32'd31,       0, 0,            0,            0);
    add_row(ROW_WORD, ReqDeliver, 15, 32'h12345678, 0, 0,            0,            0);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.op == ROW_CFG) write_count(r.val[CountW-1:0]);
      else send_word(r.req, r.idx, r.val, r.typed, r.res);
    end

    words = 0;
    while (words < NumWords) begin
      case ($urandom_range(0, 9))
        0:       cnt = 0;
        1:       cnt = 1;
        2:       cnt = 16;
        3:       cnt = 31;
        4:       cnt = CountW'($urandom_range(0, 31));
        default: cnt = CountW'($urandom_range(2, 6));
      endcase
      write_count(cnt);
      tie_mode = ($urandom_range(0, 2) == 0);
      foreach (first[i]) first[i] = 1'b1;
      phase_words = 0;
      while (!fin_sent && phase_words < 150 && words < NumWords) begin
        n = active_streams();
        cand.delete();
        for (int i = 0; i < n; i++) if (refill_wait[i]) cand.push_back(i);
        if (cand.size() == 0 || $urandom_range(0, 6) == 0) begin
          send_noise();
          words++;
        end else begin
          pick   = cand[$urandom_range(0, cand.size() - 1)];
          is_end = (phase_words > 100) ? ($urandom_range(0, 2) == 0)
                                       : ($urandom_range(0, 29) == 0);
          if (first[pick]) begin
            nxt = tie_mode ? longint'($urandom_range(0, 4)) - 2
                           : longint'($signed($urandom));
            first[pick] = 1'b0;
          end else if (tie_mode) begin
            nxt = last[pick] + $urandom_range(0, 1);
          end else begin
            nxt = last[pick] + (($urandom_range(0, 9) == 0) ? longint'($urandom)
                                                            : $urandom_range(0, 1000));
          end
          if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
          last[pick] = nxt;
          send_word(is_end ? ReqEnd : ReqDeliver, pick[IndexW-1:0], nxt[31:0], 1'b0, '0);
          words++;
          phase_words++;
        end
      end
      repeat ($urandom_range(0, 2)) send_noise();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("kway_merge_min_selector test passed");
    end else begin
      $display("kway_merge_min_selector test failed");
    end
    $finish;
  end

  // Output side: a stall pattern that changes mode now and then, plus the check.
  int rdy_mode = 0;
  int rdy_left = 0;

  always @(posedge clk_i) begin
    merge_word_t got_w;
    merge_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_w.kind  = m_axis_tuser;
      got_w.value = m_axis_tdata[31:0];
      got_w.src   = m_axis_tdata[35:32];
      if (merged_expected.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected: kind %0d value %h src %0d",
                 $time, got_w.kind, got_w.value, got_w.src);
      end else begin
        want = merged_expected.pop_front();
        if (got_w.kind != want.kind) begin
          mismatches++;
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, got_w.kind);
        end
        if (got_w.value != want.value) begin
          mismatches++;
          $display("%0t: merged_value expected %h actual %h", $time, want.value,
                   got_w.value);
        end
        if (got_w.src != want.src) begin
          mismatches++;
          $display("%0t: source_stream expected %0d actual %0d", $time, want.src,
                   got_w.src);
        end
      end
    end
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(20, 200);
    end
    rdy_left--;
    case (rdy_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= logic'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #5000000;
    $display("kway_merge_min_selector test failed");
    $finish;
  end

endmodule
